FILE: rtl/bal_pkg.sv
// Bounded array list: shared sizes, operation and status codes.
// No dependencies; imported by bounded_array_list.
package bal_pkg;

  localparam int unsigned DEPTH    = 8;
  localparam int unsigned WIDTH    = 32;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned FIDX_W   = 3;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned IN_DW    = 40;
  localparam int unsigned IN_UW    = 4;
  localparam int unsigned OUT_DW   = 8;
  localparam int unsigned OUT_UW   = 2;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DEL_INDEX  = 3'd4,
    OP_DEL_VALUE  = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOTHING   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

FILE: rtl/bounded_array_list.sv
// Bounded array list top level: slot memory, count and sequencer.
// Depends on bal_pkg.
//
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the operation and
//   the force flag, in_tdata the value and the slot position. Each request
//   yields exactly one result transfer on the out_ stream: status in
//   out_tuser, found flag, found index and entry count in out_tdata. The user
//   writes fill_value via cfg_we/cfg_wdata only while the block is idle; no logic checks it.
//
//   The slots sit in a one-port-write, one-port-read memory with registered
//   read data; a single compare/move path walks it one slot per step.
//   Push/pop at the back and refused requests finish at acceptance; push
//   front reads and writes each slot to shift it up, then writes slot 0;
//   deletes read and write each later slot to close up, then clear the last;
//   find reads and compares slot by slot; delete-value searches, then closes up.
//   One request is worked at a time; in_tready is high only when idle, no result pending.
//   A finished result waits in the output register while out_tready is low;
//   a new request may be accepted meanwhile and stalls only at completion.
//   Reset empties the list and sets fill_value to all ones.
module bounded_array_list (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bal_pkg::WORD_W-1:0]   cfg_wdata,   // fill_value
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bal_pkg::IN_DW-1:0]    in_tdata,    // value[31:0], position[34:32], zero pad
  input  logic [bal_pkg::IN_UW-1:0]    in_tuser,    // operation[2:0], force_req[3]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bal_pkg::OUT_DW-1:0]   out_tdata,   // found[0], found_index[3:1], entry_count[7:4]
  output logic [bal_pkg::OUT_UW-1:0]   out_tuser    // status[1:0]
);
  import bal_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SHR_RD, S_SHR_WR, S_PUT_FRONT, S_REMOVE, S_SHL_WR, S_SRCH_RD, S_SRCH_CMP
  } state_t;

  // almost: S_FINISH folded into a pending flag below
  state_t              state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       hit_r, hit_nxt;
  op_t                 op_r, op_nxt;
  logic [WIDTH-1:0]    val_r, val_nxt;
  logic [WIDTH-1:0]    fill_r;
  status_t             stat_r, stat_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_stat_r, out_stat_nxt;
  logic                out_found_r, out_found_nxt;
  logic [FIDX_W-1:0]   out_fidx_r, out_fidx_nxt;
  logic [COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [WIDTH-1:0]    rd_data_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  logic [WIDTH-1:0]    mem_wd;

  op_t                 in_op;
  logic [WIDTH-1:0]    in_word;
  logic [POS_W-1:0]    in_pos;
  logic                in_force;
  logic                accept;
  logic                full;
  logic                next_in_list;

  assign in_op    = op_t'(in_tuser[2:0]);
  assign in_force = in_tuser[3];
  assign in_word  = WIDTH'(in_tdata[WORD_W-1:0]);
  assign in_pos   = in_tdata[WORD_W+POS_W-1:WORD_W];

  assign in_tready    = (state_r == S_IDLE) && !pend_r;
  assign accept       = in_tvalid && in_tready;
  assign full         = (cnt_r == CW'(DEPTH));
  assign next_in_list = ((CW'(idx_r) + CW'(1)) < cnt_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {out_cnt_r, out_fidx_r, out_found_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '1;
    end else if (cfg_we) begin
      fill_r <= WIDTH'(cfg_wdata);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    stat_nxt      = stat_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_found_nxt = out_found_r;
    out_fidx_nxt  = out_fidx_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = val_r;
    mem_re        = 1'b0;
    mem_ra        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          val_nxt   = in_word;
          stat_nxt  = ST_DONE;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          pend_nxt  = 1'b1;
          case (in_op)
            OP_APPEND: begin
              if (full) begin
                stat_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = AW'(cnt_r);
                mem_wd  = in_word;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_NOTHING;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = AW'(cnt_r - CW'(1));
                mem_wd  = fill_r;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                if (in_force) begin
                  mem_we = 1'b1;
                  mem_wd = in_word;
                end else begin
                  stat_nxt = ST_FULL;
                end
              end else if (cnt_r == '0) begin
                mem_we  = 1'b1;
                mem_wd  = in_word;
                cnt_nxt = CW'(1);
              end else begin
                idx_nxt   = AW'(cnt_r);
                pend_nxt  = 1'b0;
                state_nxt = S_SHR_RD;
              end
            end
            OP_POP_FRONT: begin
              if (cnt_r == '0) begin
                stat_nxt = ST_NOTHING;
              end else if (full && !in_force) begin
                stat_nxt = ST_FULL;
              end else begin
                pend_nxt  = 1'b0;
                state_nxt = S_REMOVE;
              end
            end
            OP_DEL_INDEX: begin
              if (CW'(in_pos) >= cnt_r || (CW < POS_W && in_pos > POS_W'(DEPTH - 1))) begin
                stat_nxt = ST_NOTHING;
              end else begin
                idx_nxt   = AW'(in_pos);
                pend_nxt  = 1'b0;
                state_nxt = S_REMOVE;
              end
            end
            OP_DEL_VALUE, OP_FIND: begin
              if (in_op == OP_DEL_VALUE && in_word == fill_r) begin
                stat_nxt = ST_NOTHING;
              end else if (cnt_r == '0) begin
                stat_nxt = ST_NOT_FOUND;
              end else begin
                pend_nxt  = 1'b0;
                state_nxt = S_SRCH_RD;
              end
            end
            default: begin
              stat_nxt = ST_NOTHING;
            end
          endcase
        end else if (pend_r && (!out_valid_r || out_tready)) begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_found_nxt = found_r;
          out_fidx_nxt  = found_r ? FIDX_W'(hit_r) : '0;
          out_cnt_nxt   = COUNT_W'(cnt_r);
        end
      end
      S_SHR_RD: begin
        mem_re    = 1'b1;
        mem_ra    = idx_r - AW'(1);
        state_nxt = S_SHR_WR;
      end
      S_SHR_WR: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = rd_data_r;
        idx_nxt = idx_r - AW'(1);
        state_nxt = (idx_r == AW'(1)) ? S_PUT_FRONT : S_SHR_RD;
      end
      S_PUT_FRONT: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        pend_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_REMOVE: begin
        if (next_in_list) begin
          mem_re    = 1'b1;
          mem_ra    = idx_r + AW'(1);
          state_nxt = S_SHL_WR;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = AW'(cnt_r - CW'(1));
          mem_wd    = fill_r;
          cnt_nxt   = cnt_r - CW'(1);
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SHL_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = rd_data_r;
        idx_nxt   = idx_r + AW'(1);
        state_nxt = S_REMOVE;
      end
      S_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_ra    = idx_r;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rd_data_r == val_r) begin
          found_nxt = 1'b1;
          hit_nxt   = idx_r;
          if (op_r == OP_DEL_VALUE) begin
            state_nxt = S_REMOVE;
          end else begin
            pend_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!next_in_list) begin
          stat_nxt  = ST_NOT_FOUND;
          idx_nxt   = '0;
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    stat_r      <= stat_nxt;
    found_r     <= found_nxt;
    out_stat_r  <= out_stat_nxt;
    out_found_r <= out_found_nxt;
    out_fidx_r  <= out_fidx_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

endmodule
